FILE: src/ring_mesh_triangle_index_generator_assert.svh
// assertion macros for the ring mesh triangle index generator
`ifndef RING_MESH_TRIANGLE_INDEX_GENERATOR_ASSERT_SVH
`define RING_MESH_TRIANGLE_INDEX_GENERATOR_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define RMTIG_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("rmtig assertion failed");

// next-cycle implication, disabled while in reset
`define RMTIG_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("rmtig assertion failed");

`endif

FILE: src/rmtig_pkg.sv
// shared types and constants for the ring mesh triangle index generator
`timescale 1ns / 1ps

package rmtig_pkg;

    localparam int DEF_INDEX_BITS    = 16;
    localparam int DEF_SLICE_BITS    = 10;

    localparam int SLICE_COUNT_BITS  = 11;
    localparam int VERTEX_TOTAL_BITS = 16;
    localparam int CFG_DATA_BITS     = 16;
    localparam int CFG_INDEX_BITS    = 2;
    localparam int SECTION_BITS      = 2;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_SLICE_COUNT  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_VERTEX_TOTAL = 2'd1;

    localparam logic [SLICE_COUNT_BITS-1:0]  SLICE_COUNT_RESET  = 11'd8;
    localparam logic [VERTEX_TOTAL_BITS-1:0] VERTEX_TOTAL_RESET = 16'd18;

    typedef enum logic [SECTION_BITS-1:0] {
        PH_BOTTOM = 2'd0,
        PH_SIDE   = 2'd1,
        PH_TOP    = 2'd2
    } phase_t;

endpackage

FILE: src/ring_mesh_triangle_index_generator.sv
// the result is registered at the edge that accepts its request transaction
// throughput: one triangle per cycle while m_ready is high, set by the single output register stage
// the output register is refilled in the same cycle it is drained, so s_ready tracks m_ready
// reset: aresetn is synchronous, active low; it restores slice_count 8, vertex_total 18,
// the walk to the first bottom-fan triangle and empties the output register
`timescale 1ns / 1ps

`include "ring_mesh_triangle_index_generator_assert.svh"

module ring_mesh_triangle_index_generator #(
    parameter int INDEX_BITS = rmtig_pkg::DEF_INDEX_BITS,
    parameter int SLICE_BITS = rmtig_pkg::DEF_SLICE_BITS
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,

    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [rmtig_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [rmtig_pkg::CFG_DATA_BITS-1:0]   cfg_data,

    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic                                  s_restart,

    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [INDEX_BITS-1:0]                 m_index_a,
    output logic [INDEX_BITS-1:0]                 m_index_b,
    output logic [INDEX_BITS-1:0]                 m_index_c,
    output logic [rmtig_pkg::SECTION_BITS-1:0]    m_section,
    output logic                                  m_last
);

    // wide enough for the vertex count, a raised vertex count and any cursor value
    localparam int CW0 = (INDEX_BITS > rmtig_pkg::VERTEX_TOTAL_BITS + 1) ?
                         INDEX_BITS : rmtig_pkg::VERTEX_TOTAL_BITS + 1;
    localparam int CW  = (CW0 > SLICE_BITS + 2) ? CW0 : SLICE_BITS + 2;

    localparam logic [CW-1:0] SLICE_MAX = CW'(1) << SLICE_BITS;
    localparam logic [CW-1:0] SLICE_MIN = CW'(3);

    // configuration registers
    logic [rmtig_pkg::SLICE_COUNT_BITS-1:0]  slice_count_reg;
    logic [rmtig_pkg::VERTEX_TOTAL_BITS-1:0] vertex_total_reg;

    // walk state
    rmtig_pkg::phase_t       phase_reg, phase_next;
    logic [INDEX_BITS-1:0]   cursor_reg, cursor_next;
    logic [SLICE_BITS-1:0]   ring_pos_reg, ring_pos_next;
    logic                    second_half_reg, second_half_next;

    // output register
    logic                    m_valid_reg;
    logic [INDEX_BITS-1:0]   index_a_reg, index_a_next;
    logic [INDEX_BITS-1:0]   index_b_reg, index_b_next;
    logic [INDEX_BITS-1:0]   index_c_reg, index_c_next;
    rmtig_pkg::phase_t       section_reg, section_next;
    logic                    last_reg, last_next;

    logic                    s_fire;

    // effective state after an optional restart
    rmtig_pkg::phase_t       ph_cur;
    logic [INDEX_BITS-1:0]   cur_i;
    logic [SLICE_BITS-1:0]   rp_cur;
    logic                    sh_cur;

    logic [CW-1:0]           s_raw, s_eff, s_plus2, v_raw, v_eff, v_minus_s2, i_w;
    logic [INDEX_BITS-1:0]   s_idx, w_idx, cur_inc, top_pole;
    logic [SLICE_BITS-1:0]   rp_adv;
    logic                    rp_end, side_end, top_end;

    logic                    walk_at_start, first_bottom_out;

    assign cfg_ready = 1'b1;
    assign s_ready   = !m_valid_reg || m_ready;
    assign s_fire    = s_valid && s_ready;

    assign m_valid   = m_valid_reg;
    assign m_index_a = index_a_reg;
    assign m_index_b = index_b_reg;
    assign m_index_c = index_c_reg;
    assign m_section = section_reg;
    assign m_last    = last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slice_count_reg  <= rmtig_pkg::SLICE_COUNT_RESET;
            vertex_total_reg <= rmtig_pkg::VERTEX_TOTAL_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                rmtig_pkg::CFG_SLICE_COUNT: begin
                    slice_count_reg <= cfg_data[rmtig_pkg::SLICE_COUNT_BITS-1:0];
                end
                rmtig_pkg::CFG_VERTEX_TOTAL: begin
                    vertex_total_reg <= cfg_data[rmtig_pkg::VERTEX_TOTAL_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // clamped ring size and vertex count
    always_comb begin
        s_raw = CW'(slice_count_reg);
        if (s_raw < SLICE_MIN) begin
            s_eff = SLICE_MIN;
        end else if (s_raw > SLICE_MAX) begin
            s_eff = SLICE_MAX;
        end else begin
            s_eff = s_raw;
        end
        s_plus2    = s_eff + CW'(2);
        v_raw      = CW'(vertex_total_reg);
        v_eff      = (v_raw < s_plus2) ? s_plus2 : v_raw;
        v_minus_s2 = v_eff - s_plus2;
    end

    always_comb begin
        if (s_restart) begin
            ph_cur = rmtig_pkg::PH_BOTTOM;
            cur_i  = INDEX_BITS'(1);
            rp_cur = '0;
            sh_cur = 1'b0;
        end else begin
            ph_cur = phase_reg;
            cur_i  = cursor_reg;
            rp_cur = ring_pos_reg;
            sh_cur = second_half_reg;
        end

        i_w      = CW'(cur_i);
        s_idx    = INDEX_BITS'(s_eff);
        // left neighbor, wrapping at the ring seam
        w_idx    = (rp_cur == '0) ? (cur_i + s_idx - INDEX_BITS'(1)) : (cur_i - INDEX_BITS'(1));
        cur_inc  = cur_i + INDEX_BITS'(1);
        top_pole = INDEX_BITS'(v_eff - CW'(1));
        rp_end   = CW'(rp_cur) >= (s_eff - CW'(1));
        rp_adv   = rp_end ? '0 : (rp_cur + SLICE_BITS'(1));
        side_end = i_w >= v_minus_s2;
        top_end  = i_w >= (v_eff - CW'(2));

        phase_next       = ph_cur;
        cursor_next      = cur_i;
        ring_pos_next    = rp_cur;
        second_half_next = sh_cur;
        last_next        = 1'b0;

        unique case (ph_cur)
            rmtig_pkg::PH_SIDE: begin
                section_next = rmtig_pkg::PH_SIDE;
                if (!sh_cur) begin
                    index_a_next     = cur_i;
                    index_b_next     = cur_i + s_idx;
                    index_c_next     = w_idx + s_idx;
                    second_half_next = 1'b1;
                end else begin
                    index_a_next     = w_idx;
                    index_b_next     = cur_i;
                    index_c_next     = w_idx + s_idx;
                    second_half_next = 1'b0;
                    if (side_end) begin
                        phase_next = rmtig_pkg::PH_TOP;
                    end
                    cursor_next   = cur_inc;
                    ring_pos_next = rp_adv;
                end
            end
            rmtig_pkg::PH_TOP: begin
                section_next = rmtig_pkg::PH_TOP;
                index_a_next = top_pole;
                index_b_next = w_idx;
                index_c_next = cur_i;
                if (top_end) begin
                    last_next        = 1'b1;
                    phase_next       = rmtig_pkg::PH_BOTTOM;
                    cursor_next      = INDEX_BITS'(1);
                    ring_pos_next    = '0;
                    second_half_next = 1'b0;
                end else begin
                    cursor_next   = cur_inc;
                    ring_pos_next = rp_adv;
                end
            end
            default: begin
                section_next = rmtig_pkg::PH_BOTTOM;
                index_a_next = '0;
                index_b_next = cur_i;
                index_c_next = w_idx;
                if (rp_end) begin
                    phase_next       = (v_minus_s2 == '0) ? rmtig_pkg::PH_TOP
                                                          : rmtig_pkg::PH_SIDE;
                    cursor_next      = INDEX_BITS'(1);
                    ring_pos_next    = '0;
                    second_half_next = 1'b0;
                end else begin
                    cursor_next   = cur_inc;
                    ring_pos_next = rp_adv;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= rmtig_pkg::PH_BOTTOM;
            cursor_reg      <= INDEX_BITS'(1);
            ring_pos_reg    <= '0;
            second_half_reg <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (s_fire) begin
                phase_reg       <= phase_next;
                cursor_reg      <= cursor_next;
                ring_pos_reg    <= ring_pos_next;
                second_half_reg <= second_half_next;
                m_valid_reg     <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg     <= 1'b0;
            end
        end
    end

    // payload, no reset needed
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            index_a_reg <= index_a_next;
            index_b_reg <= index_b_next;
            index_c_reg <= index_c_next;
            section_reg <= section_next;
            last_reg    <= last_next;
        end
    end

    assign walk_at_start    = phase_reg == rmtig_pkg::PH_BOTTOM && cursor_reg == INDEX_BITS'(1)
                              && ring_pos_reg == '0;
    assign first_bottom_out = m_valid && m_section == rmtig_pkg::PH_BOTTOM && m_index_a == '0
                              && m_index_b == INDEX_BITS'(1);

    `RMTIG_ASSERT_NOW(a_last_in_top, aclk, aresetn, m_valid && m_last, m_section == rmtig_pkg::PH_TOP)
    `RMTIG_ASSERT_NEXT(a_last_rewinds, aclk, aresetn, s_fire && last_next, walk_at_start)
    `RMTIG_ASSERT_NEXT(a_restart_first, aclk, aresetn, s_fire && s_restart, first_bottom_out)
    `RMTIG_ASSERT_NOW(a_ready_when_empty, aclk, aresetn, !m_valid, s_ready)

endmodule

FILE: tb/ring_mesh_triangle_index_generator_checker.sv
// checker for the ring mesh triangle index generator: tracks the mesh walk and compares triangles
`timescale 1ns / 1ps

module ring_mesh_triangle_index_generator_checker (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    cfg_valid,
    input  logic                                    cfg_ready,
    input  logic [rmtig_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [rmtig_pkg::CFG_DATA_BITS-1:0]     cfg_data,
    input  logic                                    s_valid,
    input  logic                                    s_ready,
    input  logic                                    s_restart,
    input  logic                                    m_valid,
    input  logic                                    m_ready,
    input  logic [rmtig_pkg::DEF_INDEX_BITS-1:0]    m_index_a,
    input  logic [rmtig_pkg::DEF_INDEX_BITS-1:0]    m_index_b,
    input  logic [rmtig_pkg::DEF_INDEX_BITS-1:0]    m_index_c,
    input  logic [rmtig_pkg::SECTION_BITS-1:0]      m_section,
    input  logic                                    m_last,
    output int                                      mismatch_count,
    output int                                      triangles_pending
);

    localparam int IB = rmtig_pkg::DEF_INDEX_BITS;
    localparam int SB = rmtig_pkg::DEF_SLICE_BITS;
    localparam longint unsigned SLICE_MAX = 64'd1 << SB;

    typedef struct {
        logic [IB-1:0]     a;
        logic [IB-1:0]     b;
        logic [IB-1:0]     c;
        rmtig_pkg::phase_t section;
        logic              last;
    } triangle_t;

    logic [rmtig_pkg::SLICE_COUNT_BITS-1:0]  mesh_slices;
    logic [rmtig_pkg::VERTEX_TOTAL_BITS-1:0] mesh_vertices;
    rmtig_pkg::phase_t                       walk_phase;
    logic [IB-1:0]                           walk_cursor;
    logic [SB-1:0]                           walk_ring_pos;
    logic                                    band_second;

    triangle_t expected_triangles[$];
    int        triangles_seen;

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] seen,
                               input logic [31:0] wanted);
        if (seen !== wanted)
            report_mismatch($sformatf("triangle %0d %s: got %0d, expected %0d",
                                      triangles_seen, name, seen, wanted));
    endtask

    task automatic restart_walk();
        walk_phase    = rmtig_pkg::PH_BOTTOM;
        walk_cursor   = IB'(1);
        walk_ring_pos = '0;
        band_second   = 1'b0;
    endtask

    task automatic advance_cursor(input longint unsigned i, input longint unsigned rp,
                                  input longint unsigned s);
        walk_cursor   = IB'(i + 1);
        walk_ring_pos = (rp >= s - 1) ? '0 : SB'(rp + 1);
    endtask

    task automatic step_mesh_walk(input logic restart, output triangle_t t);
        longint unsigned s, v, i, w, rp;
        s = 64'(mesh_slices);
        if (s < 3) s = 3;
        if (s > SLICE_MAX) s = SLICE_MAX;
        v = 64'(mesh_vertices);
        if (v < s + 2) v = s + 2;
        if (restart) restart_walk();
        i  = 64'(walk_cursor);
        rp = 64'(walk_ring_pos);
        w  = (rp == 0) ? i + s - 1 : i - 1;
        t.last = 1'b0;
        case (walk_phase)
            rmtig_pkg::PH_SIDE: begin
                t.section = rmtig_pkg::PH_SIDE;
                if (!band_second) begin
                    t.a = IB'(i);
                    t.b = IB'(i + s);
                    t.c = IB'(w + s);
                    band_second = 1'b1;
                end else begin
                    t.a = IB'(w);
                    t.b = IB'(i);
                    t.c = IB'(w + s);
                    band_second = 1'b0;
                    if (i >= v - s - 2) walk_phase = rmtig_pkg::PH_TOP;
                    advance_cursor(i, rp, s);
                end
            end
            rmtig_pkg::PH_TOP: begin
                t.section = rmtig_pkg::PH_TOP;
                t.a = IB'(v - 1);
                t.b = IB'(w);
                t.c = IB'(i);
                if (i >= v - 2) begin
                    t.last = 1'b1;
                    restart_walk();
                end else begin
                    advance_cursor(i, rp, s);
                end
            end
            default: begin
                t.section = rmtig_pkg::PH_BOTTOM;
                t.a = '0;
                t.b = IB'(i);
                t.c = IB'(w);
                if (rp >= s - 1) begin
                    walk_phase    = (v - s - 2 < 1) ? rmtig_pkg::PH_TOP : rmtig_pkg::PH_SIDE;
                    walk_cursor   = IB'(1);
                    walk_ring_pos = '0;
                    band_second   = 1'b0;
                end else begin
                    advance_cursor(i, rp, s);
                end
            end
        endcase
    endtask

    always @(posedge aclk) begin : watch
        triangle_t want;
        if (!aresetn) begin
            mesh_slices   = rmtig_pkg::SLICE_COUNT_RESET;
            mesh_vertices = rmtig_pkg::VERTEX_TOTAL_RESET;
            restart_walk();
            expected_triangles.delete();
            triangles_pending <= 0;
        end else begin
            if (m_valid && m_ready) begin
                triangles_seen++;
                if (expected_triangles.size() == 0) begin
                    report_mismatch($sformatf("triangle %0d arrived with nothing pending",
                                              triangles_seen));
                end else begin
                    want = expected_triangles.pop_front();
                    check_field("index_a", 32'(m_index_a), 32'(want.a));
                    check_field("index_b", 32'(m_index_b), 32'(want.b));
                    check_field("index_c", 32'(m_index_c), 32'(want.c));
                    check_field("section", 32'(m_section), 32'(want.section));
                    check_field("last", 32'(m_last), 32'(want.last));
                end
            end
            if (s_valid && s_ready) begin
                step_mesh_walk(s_restart, want);
                expected_triangles.push_back(want);
            end
            // a register write takes effect after the transaction of the same edge
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    rmtig_pkg::CFG_SLICE_COUNT:
                        mesh_slices = cfg_data[rmtig_pkg::SLICE_COUNT_BITS-1:0];
                    rmtig_pkg::CFG_VERTEX_TOTAL:
                        mesh_vertices = cfg_data[rmtig_pkg::VERTEX_TOTAL_BITS-1:0];
                    default: ;
                endcase
            end
            triangles_pending <= expected_triangles.size();
        end
    end

endmodule

FILE: tb/ring_mesh_triangle_index_generator_tb.sv
// testbench top for the ring mesh triangle index generator: stimulus, pacing and verdict
`timescale 1ns / 1ps

module ring_mesh_triangle_index_generator_tb;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int REQUEST_TARGET = 1200;
    localparam int DB             = rmtig_pkg::CFG_DATA_BITS;
    localparam int SCB            = rmtig_pkg::SLICE_COUNT_BITS;
    localparam int HI_BITS        = DB - SCB;

    logic                                  aclk      = 1'b0;
    logic                                  aresetn   = 1'b0;
    logic                                  cfg_valid = 1'b0;
    logic                                  cfg_ready;
    logic [rmtig_pkg::CFG_INDEX_BITS-1:0]  cfg_index = rmtig_pkg::CFG_SLICE_COUNT;
    logic [DB-1:0]                         cfg_data  = '0;
    logic                                  s_valid   = 1'b0;
    logic                                  s_ready;
    logic                                  s_restart = 1'b0;
    logic                                  m_valid;
    logic                                  m_ready   = 1'b0;
    logic [rmtig_pkg::DEF_INDEX_BITS-1:0]  m_index_a;
    logic [rmtig_pkg::DEF_INDEX_BITS-1:0]  m_index_b;
    logic [rmtig_pkg::DEF_INDEX_BITS-1:0]  m_index_c;
    logic [rmtig_pkg::SECTION_BITS-1:0]    m_section;
    logic                                  m_last;

    int mismatch_count;
    int triangles_pending;
    int requests_sent;
    int idle_cycles;
    bit sender_burst;

    ring_mesh_triangle_index_generator dut (.*);

    ring_mesh_triangle_index_generator_checker triangle_checker (.*);

    initial begin
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // result side stalls: mostly short, a few long, some long stall-free runs
    initial begin : receiver_pacing
        int r;
        forever begin
            r = $urandom_range(0, 99);
            m_ready <= 1'b1;
            repeat (r < 10 ? $urandom_range(100, 300) : $urandom_range(1, 12)) @(posedge aclk);
            m_ready <= 1'b0;
            repeat (r < 85 ? $urandom_range(1, 3) : $urandom_range(8, 30)) @(posedge aclk);
        end
    end

    function automatic int pick_gap();
        int r;
        if (sender_burst) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic send_request(input logic restart);
        int gap;
        s_valid   <= 1'b1;
        s_restart <= restart;
        do @(posedge aclk); while (!s_ready);
        requests_sent++;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic write_reg(input logic [rmtig_pkg::CFG_INDEX_BITS-1:0] idx,
                             input logic [DB-1:0] data, input bit more);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        if (!more) cfg_valid <= 1'b0;
    endtask

    task automatic set_mesh(input logic [DB-1:0] slices,
                            input logic [DB-1:0] vertices);
        write_reg(rmtig_pkg::CFG_SLICE_COUNT, slices, 1'b1);
        write_reg(rmtig_pkg::CFG_VERTEX_TOTAL, vertices, 1'b0);
    endtask

    // wait until every triangle in flight has been delivered
    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (triangles_pending != 0);
    endtask

    task automatic random_phase();
        int r, pick, s, v, n, span;
        logic [DB-1:0] slice_word;
        r = $urandom_range(0, 99);
        s = $urandom_range(3, 10);
        if (r < 55) begin
            v = s * $urandom_range(1, 5) + 2;
        end else if (r < 70) begin
            v = $urandom_range(0, s * 5 + 4);
        end else if (r < 78) begin
            s = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 2) : $urandom_range(1025, 2047);
            v = $urandom_range(0, 40);
        end else if (r < 84) begin
            s = $urandom_range(11, 64);
            v = s * $urandom_range(1, 3) + 2;
        end else if (r < 88) begin
            s = ($urandom_range(0, 1) == 0) ? 1024 : 2047;
            v = $urandom_range(0, 3000);
        end else begin
            v = ($urandom_range(0, 1) == 0) ? 65535 : $urandom_range(0, 65535);
        end
        slice_word = DB'(s);
        if ($urandom_range(0, 9) == 0) slice_word[DB-1:SCB] = HI_BITS'($urandom);
        pick = $urandom_range(0, 99);
        if (r < 92) begin
            if (pick < 12)
                write_reg(rmtig_pkg::CFG_SLICE_COUNT, slice_word, 1'b0);
            else if (pick < 24)
                write_reg(rmtig_pkg::CFG_VERTEX_TOTAL, DB'(v), 1'b0);
            else
                set_mesh(slice_word, DB'(v));
        end
        sender_burst = ($urandom_range(0, 3) == 0);
        span = 2 * v + 12;
        if (span > 150) span = 150;
        n = $urandom_range(1, span);
        repeat (n) send_request($urandom_range(0, 99) < 3);
        drain();
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // smallest mesh: full list, wrap to the start, restart mid-list
        set_mesh(16'd3, 16'd5);
        repeat (7) send_request(1'b0);
        send_request(1'b1);
        repeat (2) send_request(1'b0);
        drain();

        // slice count below range, vertex total too small
        set_mesh(16'd0, 16'd0);
        send_request(1'b1);
        repeat (3) send_request(1'b0);
        drain();

        // slice count above range with upper data bits set, largest vertex total
        set_mesh(16'hFFFF, 16'hFFFF);
        send_request(1'b1);
        repeat (2) send_request(1'b0);
        drain();

        // shrink the ring mid bottom fan, then move the top fan boundary around
        write_reg(rmtig_pkg::CFG_SLICE_COUNT, 16'd3, 1'b0);
        repeat (3) send_request(1'b0);
        drain();
        write_reg(rmtig_pkg::CFG_VERTEX_TOTAL, 16'd6, 1'b0);
        repeat (3) send_request(1'b0);
        drain();
        write_reg(rmtig_pkg::CFG_VERTEX_TOTAL, 16'hFFFF, 1'b0);
        repeat (2) send_request(1'b0);
        drain();
        write_reg(rmtig_pkg::CFG_VERTEX_TOTAL, 16'd6, 1'b0);
        send_request(1'b0);
        drain();

        while (requests_sent < REQUEST_TARGET) random_phase();

        repeat (8) @(posedge aclk);
        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+src
src/rmtig_pkg.sv
src/ring_mesh_triangle_index_generator.sv
tb/ring_mesh_triangle_index_generator_checker.sv
tb/ring_mesh_triangle_index_generator_tb.sv
